>>> design/ocef_pkg.sv
// Package for the occupancy cell evidence fusion block.
// Holds the cell, payload, configuration and control types and the fusion codes.
// No dependencies; every other design file imports it.
`default_nettype none

package ocef_pkg;

   // Occupancy codes.
   localparam logic [1:0] OCC_UNKNOWN     = 2'd0;
   localparam logic [1:0] OCC_FREE        = 2'd1;
   localparam logic [1:0] OCC_OCCUPIED    = 2'd2;
   localparam logic [1:0] OCC_UNSUPPORTED = 2'd3;

   // Evidence codes.
   localparam logic [1:0] EV_NONE        = 2'd0;
   localparam logic [1:0] EV_DEPTH       = 2'd1;
   localparam logic [1:0] EV_SCENE_FLOOR = 2'd2;
   localparam logic [1:0] EV_SCENE_WALL  = 2'd3;

   // Fusion constants.
   localparam logic [31:0] VOTE_SPACING_MS = 32'd80;
   localparam logic [16:0] SAME_HEIGHT_MM  = 17'd20;
   localparam logic [2:0]  VOTES_WALL      = 3'd5;
   localparam logic [2:0]  VOTES_OTHER     = 3'd3;
   localparam logic [2:0]  VOTES_MAX       = 3'd7;

   // Configuration register indexes and reset values.
   localparam logic REG_MAX_STEP      = 1'b0;
   localparam logic REG_LIVE_EVIDENCE = 1'b1;
   localparam logic [9:0]  MAX_STEP_RESET      = 10'd200;
   localparam logic [15:0] LIVE_EVIDENCE_RESET = 16'd1000;

   typedef struct packed {
      logic [7:0]         cell_x;
      logic [7:0]         cell_y;
      logic [1:0]         obs_occupancy;
      logic [1:0]         obs_evidence;
      logic               obs_has_floor;
      logic               obs_has_clearance;
      logic signed [15:0] obs_floor_mm;
      logic [31:0]        obs_time_ms;
   } req_type;

   typedef struct packed {
      logic        changed;
      logic [31:0] revision;
   } rsp_type;

   // One stored grid cell, 57 bits.
   typedef struct packed {
      logic [1:0]         occ;
      logic [1:0]         ev;
      logic               floor_ok;
      logic               clear_ok;
      logic signed [15:0] floor_mm;
      logic [31:0]        time_ms;
      logic [2:0]         votes;
   } cell_type;

   typedef struct packed {
      logic [9:0]  max_step_mm;
      logic [15:0] live_evidence_ms;
   } cfg_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

>>> design/ocef_csr.sv
// Configuration registers of the fusion block behind an APB-style port.
// Depends on ocef_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module ocef_csr
   import ocef_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready,
   output      cfg_type     cfg
);

   logic [9:0]  max_step_ff;
   logic [9:0]  max_step_in;
   logic [15:0] live_ff;
   logic [15:0] live_in;
   logic        wr_en;
   logic        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      max_step_in = max_step_ff;
      live_in     = live_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MAX_STEP:      max_step_in = pwdata[9:0];
            REG_LIVE_EVIDENCE: live_in     = pwdata[15:0];
            default:           max_step_in = max_step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= MAX_STEP_RESET;
         live_ff     <= LIVE_EVIDENCE_RESET;
      end else begin
         max_step_ff <= max_step_in;
         live_ff     <= live_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAX_STEP:      prdata = {22'd0, max_step_ff};
         REG_LIVE_EVIDENCE: prdata = {16'd0, live_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign cfg.max_step_mm      = max_step_ff;
   assign cfg.live_evidence_ms = live_ff;

endmodule

`default_nettype wire

>>> design/ocef_ctrl.sv
// Controller state machine of the fusion block: clearing sweep, accept, update.
// Depends on ocef_pkg for the command and status structs.
`default_nettype none

module ocef_ctrl
   import ocef_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.capture  = req_valid && req_ready;
   assign cmd.clear_wr = (state_ff == ST_CLEAR);
   assign cmd.commit   = (state_ff == ST_UPDATE) && !status.out_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_UPDATE)
      else $error("accepted word did not move to update");

   a_update_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && !status.out_busy) |=> state_ff == ST_IDLE)
      else $error("update did not return to idle");

   a_no_reclear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> state_ff != ST_CLEAR)
      else $error("clearing sweep restarted without reset");

endmodule

`default_nettype wire

>>> design/ocef_datapath.sv
// Datapath of the fusion block: cell memory, fusion rules, revision counter
// and the result register. Depends on ocef_pkg; driven by ocef_ctrl commands.
`default_nettype none

module ocef_datapath
   import ocef_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire req_type    req_data,
   input  wire logic       rsp_ready,
   output      logic       rsp_valid,
   output rsp_type         rsp_data,
   input  wire ctrl_cmd_type cmd,
   output ctrl_status_type status
);

   // Coordinates are 8 bits, so at most 256 columns and rows are ever used.
   localparam int SIDE_USED = (GRID_SIDE < 256) ? GRID_SIDE : 256;
   localparam int DEPTH     = SIDE_USED * SIDE_USED;
   localparam int ADDR_W    = $clog2(DEPTH);

   cell_type             mem [DEPTH];
   cell_type             cell_ff;
   req_type              obs_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic                 in_grid_ff;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [ADDR_W-1:0]    clr_addr_in;
   logic [31:0]          rev_ff;
   logic [31:0]          rev_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic [ADDR_W-1:0]    rd_addr;
   logic                 req_in_grid;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   cell_type             mem_wdata;

   logic [31:0]          dt;
   logic signed [16:0]   fdiff;
   logic [16:0]          fabs;
   logic                 structural;
   logic                 ignore;
   logic                 vote_path;
   logic                 vote_bad;
   logic [2:0]           votes_inc;
   logic                 vote_pending;
   logic                 keep_floor;
   logic                 changed_full;
   cell_type             new_cell;
   cell_type             vote_cell;
   logic                 upd_wr;
   logic                 upd_changed;

   assign req_in_grid = ({1'b0, req_data.cell_x} < 9'(SIDE_USED))
                     && ({1'b0, req_data.cell_y} < 9'(SIDE_USED));
   assign rd_addr = req_in_grid
      ? ADDR_W'(32'(req_data.cell_y) * 32'(SIDE_USED) + 32'(req_data.cell_x))
      : '0;

   // Fusion rules on the captured observation and the cell read at accept.
   always_comb begin
      dt         = obs_ff.obs_time_ms - cell_ff.time_ms;
      fdiff      = {obs_ff.obs_floor_mm[15], obs_ff.obs_floor_mm}
                 - {cell_ff.floor_mm[15], cell_ff.floor_mm};
      fabs       = fdiff[16] ? 17'(-fdiff) : 17'(fdiff);
      structural = (cell_ff.ev == EV_SCENE_WALL);

      ignore = (obs_ff.obs_occupancy == OCC_UNKNOWN) || !in_grid_ff
            || (structural && obs_ff.obs_occupancy != OCC_FREE
                && obs_ff.obs_evidence != EV_SCENE_WALL);

      vote_path = (obs_ff.obs_occupancy == OCC_FREE)
               && (cell_ff.occ == OCC_OCCUPIED || cell_ff.occ == OCC_UNSUPPORTED);
      vote_bad  = (obs_ff.obs_evidence != EV_DEPTH) || !obs_ff.obs_has_floor
               || !obs_ff.obs_has_clearance || (dt < VOTE_SPACING_MS);
      votes_inc = (cell_ff.votes != VOTES_MAX) ? cell_ff.votes + 3'd1 : VOTES_MAX;
      vote_pending = votes_inc < (structural ? VOTES_WALL : VOTES_OTHER);

      // A confirming depth sample over free scene floor keeps the scene floor.
      keep_floor = (cell_ff.ev == EV_SCENE_FLOOR) && (cell_ff.occ == OCC_FREE)
                && cell_ff.floor_ok && cell_ff.clear_ok
                && (obs_ff.obs_evidence == EV_DEPTH)
                && (obs_ff.obs_occupancy == OCC_FREE)
                && obs_ff.obs_has_floor && obs_ff.obs_has_clearance
                && (fabs <= {7'd0, cfg.max_step_mm});

      new_cell.occ      = obs_ff.obs_occupancy;
      new_cell.ev       = keep_floor ? EV_SCENE_FLOOR : obs_ff.obs_evidence;
      new_cell.floor_ok = obs_ff.obs_has_floor;
      new_cell.clear_ok = obs_ff.obs_has_clearance;
      new_cell.floor_mm = keep_floor ? cell_ff.floor_mm : obs_ff.obs_floor_mm;
      new_cell.time_ms  = obs_ff.obs_time_ms;
      new_cell.votes    = '0;

      vote_cell         = cell_ff;
      vote_cell.time_ms = obs_ff.obs_time_ms;
      vote_cell.votes   = votes_inc;

      // When the floor is kept the stored height is unchanged.
      changed_full = (cell_ff.occ != new_cell.occ) || (cell_ff.ev != new_cell.ev)
                  || (cell_ff.floor_ok != new_cell.floor_ok)
                  || (cell_ff.clear_ok != new_cell.clear_ok)
                  || (!keep_floor && fabs > SAME_HEIGHT_MM)
                  || (cell_ff.ev == EV_DEPTH && dt > {16'd0, cfg.live_evidence_ms});

      upd_wr      = 1'b0;
      upd_changed = 1'b0;
      mem_wdata   = new_cell;
      priority if (ignore) begin
         upd_wr = 1'b0;
      end else if (vote_path && vote_bad) begin
         upd_wr = 1'b0;
      end else if (vote_path && vote_pending) begin
         upd_wr    = 1'b1;
         mem_wdata = vote_cell;
      end else begin
         upd_wr      = 1'b1;
         upd_changed = changed_full;
      end

      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.commit) begin
         mem_we = upd_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.capture) cell_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         obs_ff     <= req_data;
         addr_ff    <= rd_addr;
         in_grid_ff <= req_in_grid;
      end
      if (cmd.commit) begin
         rsp_data_ff.changed  <= upd_changed;
         rsp_data_ff.revision <= rev_in;
      end
   end

   assign clr_addr_in  = cmd.clear_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;
   assign rev_in       = (cmd.commit && upd_changed) ? rev_ff + 32'd1 : rev_ff;
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

   a_rev_step: assert property (@(posedge clock) disable iff (reset)
      rev_ff != $past(rev_ff) |-> rev_ff == $past(rev_ff) + 32'd1)
      else $error("revision moved by more than one");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result word appeared without an update");

   a_commit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || rsp_ready)
      else $error("update overwrote a pending result word");

endmodule

`default_nettype wire

>>> design/occupancy_cell_evidence_fusion.sv
// Occupancy cell evidence fusion, top level.
// Input channel req_*: one word per observation of one grid cell; the block
// reads the stored cell, applies the fusion rules and writes the cell back.
// Result channel rsp_*: one word per observation with the changed flag and
// the wrapping map revision after that observation.
// Configuration: APB-style port, max_step_mm at byte 0, live_evidence_ms at 4.
// For each observation the accept edge reads the cell from the
// single-port cell memory; the update state then writes it back and loads the
// result register once that register is free. No new word is accepted until
// the update is done, and the result word is registered as the update commits.
// After reset the cell memory is swept to its cleared state, one cell per
// cycle: GRID_SIDE*GRID_SIDE cells below a side of 256, and 65536 cells at
// 256 or above, since coordinates are 8 bits; req_ready stays low
// during the sweep while configuration writes are taken as usual.
// If the receiver stalls, the result register holds its word; one more
// observation may be accepted, then the block waits for rsp_ready.
// Depends on ocef_pkg, ocef_csr, ocef_ctrl and ocef_datapath.
`default_nettype none

module occupancy_cell_evidence_fusion
   import ocef_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ocef_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ocef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ocef_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire
